>>> rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Request codes, register indexes, character constants, sequencer states
// and small helpers for geometry saturation and whitespace detection.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int CELL_W = 16;

  localparam logic [7:0]        CH_TAB     = 8'd9;
  localparam logic [7:0]        CH_NEWLINE = 8'd10;
  localparam logic [7:0]        CH_SPACE   = 8'd32;
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_SET   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    CFG_COLOR   = 2'd0,
    CFG_COLUMNS = 2'd1,
    CFG_ROWS    = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT_ADDR,
    ST_PUT_WR,
    ST_FILL,
    ST_SCROLL_ADDR,
    ST_COPY,
    ST_READ,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    FK_NEWLINE,
    FK_SCROLL,
    FK_CLEAR
  } fill_kind_t;

  // Saturate a raw count to 1..max_val and return it minus one.
  function automatic int eff_m1(input int raw, input int max_val);
    int res;
    if (raw < 1) begin
      res = 0;
    end else if (raw > max_val) begin
      res = max_val - 1;
    end else begin
      res = raw - 1;
    end
    return res;
  endfunction

  function automatic logic is_white(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// tcw_screen_ram: character/attribute screen store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_screen_ram
  import tcw_pkg::*;
#(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [CELL_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tcw_addr_unit.sv
// ----------------------------------------------------------------------------
// tcw_addr_unit: shared cell address unit
// Registered row * columns + column; holds its result while not enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_addr_unit
  import tcw_pkg::*;
#(
  parameter int ROW_W  = 5,
  parameter int COL_W  = 7,
  parameter int ADDR_W = 11
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [ROW_W-1:0]  row,
  input  wire logic [COL_W-1:0]  col,
  input  wire logic [COL_W-1:0]  cols_m1,
  output logic      [ADDR_W-1:0] addr_q
);

  localparam int PROD_W = ROW_W + COL_W + 1;

  logic [PROD_W-1:0] cols_full;
  logic [PROD_W-1:0] lin;

  always_comb begin
    cols_full = PROD_W'(cols_m1) + PROD_W'(1);
    lin       = PROD_W'(row) * cols_full + PROD_W'(col);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      addr_q <= ADDR_W'(lin);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top: text console with screen store and cursor
// Takes one request per transfer (put character, set cursor, clear screen,
// read cell) and returns one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a request transfers at a rising edge with start high and busy low.
//   Output: out_valid strobes for one cycle with the cursor, the display
//   cursor position and the read cell; the receiver cannot stall, so the
//   result is simply presented and dropped after that cycle.
//   Config: cfg_we writes text_color, columns_in_use or rows_in_use at once;
//   write only while busy is low. Geometry writes clamp the cursor.
// Steps (C columns, R rows in use): set cursor goes straight to the
//   strobe, read cell passes ST_READ, a character ST_PUT_ADDR and
//   ST_PUT_WR; a tab repeats these for four spaces; a newline blanks
//   the rest of the row in ST_FILL. A wrap past the last row adds a
//   scroll: ST_COPY moves (R-1)*C cells up, ST_FILL blanks the bottom
//   row. Clear screen fills R*C cells in ST_FILL. The single store
//   write port takes one cell per cycle. A new request waits for ST_IDLE.
// Reset: a clearing pass writes every store cell to a space in color 7,
//   with busy high; cursor and display cursor go to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int MAX_COLUMNS = 80,
  parameter int MAX_ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [6:0]  in_set_column,
  input  wire logic [4:0]  in_set_row,
  input  wire logic [10:0] in_cell_index,
  output logic             out_valid,
  output logic [6:0]       out_cursor_column,
  output logic [4:0]       out_cursor_row,
  output logic [10:0]      out_hw_cursor_position,
  output logic [7:0]       out_cell_char,
  output logic [7:0]       out_cell_color,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  localparam int STORE_CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W      = $clog2(STORE_CELLS);
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);

  // Control state
  state_t            state_r,     state_nxt;
  fill_kind_t        fill_kind_r, fill_kind_nxt;
  logic [1:0]        tab_left_r,  tab_left_nxt;
  logic [ADDR_W-1:0] ptr_r,       ptr_nxt;
  logic [COL_W-1:0]  fill_col_r,  fill_col_nxt;
  logic [ROW_W-1:0]  fill_rows_r, fill_rows_nxt;
  logic [ADDR_W-1:0] copy_cnt_r,  copy_cnt_nxt;
  logic [COL_W-1:0]  cur_col_r,   cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r,   cur_row_nxt;
  logic [10:0]       dc_r,        dc_nxt;
  logic [7:0]        color_r,     color_nxt;
  logic [6:0]        cols_cfg_r,  cols_cfg_nxt;
  logic [4:0]        rows_cfg_r,  rows_cfg_nxt;

  // Payload
  logic [7:0]        ch_r,        ch_nxt;
  logic              rd_hit_r,    rd_hit_nxt;
  logic [CELL_W-1:0] cell_r,      cell_nxt;

  // Effective geometry, minus one
  logic [COL_W-1:0]  cols_m1;
  logic [ROW_W-1:0]  rows_m1;
  logic [COL_W-1:0]  new_cols_m1;
  logic [ROW_W-1:0]  new_rows_m1;

  // Store and address unit hookup
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;
  logic              addr_en;
  logic [ROW_W-1:0]  addr_row;
  logic [COL_W-1:0]  addr_col;
  logic [ADDR_W-1:0] addr_q;

  logic [7:0]        put_chr;
  logic              fill_last;

  tcw_screen_ram #(
    .DEPTH  (STORE_CELLS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_addr_unit #(
    .ROW_W  (ROW_W),
    .COL_W  (COL_W),
    .ADDR_W (ADDR_W)
  ) u_addr (
    .clk     (clk),
    .en      (addr_en),
    .row     (addr_row),
    .col     (addr_col),
    .cols_m1 (cols_m1),
    .addr_q  (addr_q)
  );

  always_comb begin
    cols_m1     = COL_W'(eff_m1(int'(cols_cfg_r), MAX_COLUMNS));
    rows_m1     = ROW_W'(eff_m1(int'(rows_cfg_r), MAX_ROWS));
    new_cols_m1 = COL_W'(eff_m1(int'(cfg_wdata[6:0]), MAX_COLUMNS));
    new_rows_m1 = ROW_W'(eff_m1(int'(cfg_wdata[4:0]), MAX_ROWS));
  end

  always_comb begin
    state_nxt     = state_r;
    fill_kind_nxt = fill_kind_r;
    tab_left_nxt  = tab_left_r;
    ptr_nxt       = ptr_r;
    fill_col_nxt  = fill_col_r;
    fill_rows_nxt = fill_rows_r;
    copy_cnt_nxt  = copy_cnt_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    dc_nxt        = dc_r;
    color_nxt     = color_r;
    cols_cfg_nxt  = cols_cfg_r;
    rows_cfg_nxt  = rows_cfg_r;
    ch_nxt        = ch_r;
    rd_hit_nxt    = rd_hit_r;
    cell_nxt      = cell_r;

    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = {color_r, CH_SPACE};
    ram_re    = 1'b0;
    ram_raddr = ADDR_W'(in_cell_index);
    addr_en   = 1'b0;
    addr_row  = cur_row_r;
    addr_col  = cur_col_r;

    put_chr   = (ch_r == CH_TAB) ? CH_SPACE : ch_r;
    fill_last = (fill_col_r == cols_m1) && (fill_rows_r == '0);

    case (state_r)
      ST_INIT: begin
        // Reset clearing pass over the whole store.
        ram_we    = 1'b1;
        ram_wdata = BLANK_CELL;
        ptr_nxt   = ptr_r + ADDR_W'(1);
        if (ptr_r == ADDR_W'(STORE_CELLS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          ch_nxt   = in_char_code;
          cell_nxt = '0;
          case (req_type_t'(in_req_type))
            REQ_PUT: begin
              // A tab is four spaces: this one plus three more.
              tab_left_nxt = (in_char_code == CH_TAB) ? 2'd3 : 2'd0;
              state_nxt    = ST_PUT_ADDR;
            end
            REQ_SET: begin
              if (int'(in_set_column) > int'(cols_m1)) begin
                cur_col_nxt = cols_m1;
              end else begin
                cur_col_nxt = COL_W'(in_set_column);
              end
              if (int'(in_set_row) > int'(rows_m1)) begin
                cur_row_nxt = rows_m1;
              end else begin
                cur_row_nxt = ROW_W'(in_set_row);
              end
              state_nxt = ST_DONE;
            end
            REQ_CLEAR: begin
              ptr_nxt       = '0;
              fill_col_nxt  = '0;
              fill_rows_nxt = rows_m1;
              fill_kind_nxt = FK_CLEAR;
              state_nxt     = ST_FILL;
            end
            REQ_READ: begin
              rd_hit_nxt = (int'(in_cell_index) < STORE_CELLS);
              ram_re     = (int'(in_cell_index) < STORE_CELLS);
              state_nxt  = ST_READ;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_PUT_ADDR: begin
        addr_en   = 1'b1;
        state_nxt = ST_PUT_WR;
      end

      ST_PUT_WR: begin
        if (ch_r == CH_NEWLINE) begin
          // Blank from the cursor to the end of the row.
          ptr_nxt       = addr_q;
          fill_col_nxt  = cur_col_r;
          fill_rows_nxt = '0;
          fill_kind_nxt = FK_NEWLINE;
          state_nxt     = ST_FILL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = addr_q;
          ram_wdata = {color_r, put_chr};
          if (!is_white(put_chr)) begin
            dc_nxt = 11'(addr_q);
          end
          if (cur_col_r == cols_m1) begin
            cur_col_nxt = '0;
            if (cur_row_r == rows_m1) begin
              copy_cnt_nxt = '0;
              state_nxt    = ST_SCROLL_ADDR;
            end else begin
              cur_row_nxt = cur_row_r + ROW_W'(1);
            end
          end else begin
            cur_col_nxt = cur_col_r + COL_W'(1);
          end
          if (!((cur_col_r == cols_m1) && (cur_row_r == rows_m1))) begin
            if (tab_left_r != 2'd0) begin
              tab_left_nxt = tab_left_r - 2'd1;
              state_nxt    = ST_PUT_ADDR;
            end else begin
              state_nxt = ST_DONE;
            end
          end
        end
      end

      ST_FILL: begin
        ram_we  = 1'b1;
        ptr_nxt = ptr_r + ADDR_W'(1);
        if (fill_col_r == cols_m1) begin
          fill_col_nxt  = '0;
          fill_rows_nxt = fill_rows_r - ROW_W'(1);
        end else begin
          fill_col_nxt = fill_col_r + COL_W'(1);
        end
        if (fill_last) begin
          case (fill_kind_r)
            FK_NEWLINE: begin
              cur_col_nxt = '0;
              if (cur_row_r == rows_m1) begin
                copy_cnt_nxt = '0;
                state_nxt    = ST_SCROLL_ADDR;
              end else begin
                cur_row_nxt = cur_row_r + ROW_W'(1);
                state_nxt   = ST_DONE;
              end
            end
            FK_SCROLL: begin
              // Park at the start of the bottom row, then resume a tab.
              cur_col_nxt = '0;
              cur_row_nxt = rows_m1;
              dc_nxt      = 11'(addr_q);
              if (tab_left_r != 2'd0) begin
                tab_left_nxt = tab_left_r - 2'd1;
                state_nxt    = ST_PUT_ADDR;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            FK_CLEAR: begin
              cur_col_nxt = '0;
              cur_row_nxt = '0;
              state_nxt   = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SCROLL_ADDR: begin
        // Start of the bottom row is also the number of cells to move.
        addr_en   = 1'b1;
        addr_row  = rows_m1;
        addr_col  = '0;
        state_nxt = ST_COPY;
      end

      ST_COPY: begin
        // Stream: read cell k+C while writing the cell read last cycle to k-1.
        if (copy_cnt_r != addr_q) begin
          ram_re       = 1'b1;
          ram_raddr    = ADDR_W'(32'(copy_cnt_r) + 32'(cols_m1) + 32'd1);
          copy_cnt_nxt = copy_cnt_r + ADDR_W'(1);
        end
        if (copy_cnt_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = copy_cnt_r - ADDR_W'(1);
          ram_wdata = ram_rdata;
        end
        if (copy_cnt_r == addr_q) begin
          ptr_nxt       = addr_q;
          fill_col_nxt  = '0;
          fill_rows_nxt = '0;
          fill_kind_nxt = FK_SCROLL;
          state_nxt     = ST_FILL;
        end
      end

      ST_READ: begin
        cell_nxt  = rd_hit_r ? ram_rdata : '0;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Register writes; geometry changes clamp the cursor at once.
    if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_COLOR: begin
          color_nxt = cfg_wdata;
        end
        CFG_COLUMNS: begin
          cols_cfg_nxt = cfg_wdata[6:0];
          if (cur_col_nxt > new_cols_m1) begin
            cur_col_nxt = new_cols_m1;
          end
        end
        CFG_ROWS: begin
          rows_cfg_nxt = cfg_wdata[4:0];
          if (cur_row_nxt > new_rows_m1) begin
            cur_row_nxt = new_rows_m1;
          end
        end
        default: begin
          color_nxt = color_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      fill_kind_r <= FK_CLEAR;
      tab_left_r  <= '0;
      ptr_r       <= '0;
      fill_col_r  <= '0;
      fill_rows_r <= '0;
      copy_cnt_r  <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      dc_r        <= '0;
      color_r     <= 8'd7;
      cols_cfg_r  <= 7'd80;
      rows_cfg_r  <= 5'd25;
    end else begin
      state_r     <= state_nxt;
      fill_kind_r <= fill_kind_nxt;
      tab_left_r  <= tab_left_nxt;
      ptr_r       <= ptr_nxt;
      fill_col_r  <= fill_col_nxt;
      fill_rows_r <= fill_rows_nxt;
      copy_cnt_r  <= copy_cnt_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      dc_r        <= dc_nxt;
      color_r     <= color_nxt;
      cols_cfg_r  <= cols_cfg_nxt;
      rows_cfg_r  <= rows_cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r     <= ch_nxt;
    rd_hit_r <= rd_hit_nxt;
    cell_r   <= cell_nxt;
  end

  // Hold results on registers; the strobe marks the single valid cycle.
  assign busy                   = (state_r != ST_IDLE);
  assign out_valid              = (state_r == ST_DONE);
  assign out_cursor_column      = 7'(cur_col_r);
  assign out_cursor_row         = 5'(cur_row_r);
  assign out_hw_cursor_position = dc_r;
  assign out_cell_char          = cell_r[7:0];
  assign out_cell_color         = cell_r[15:8];

endmodule

`default_nettype wire
